// File: rtl/dpxmj_pkg.sv
// ----------------------------------------------------------------------------
// dpxmj_pkg
// Shared types and constants of the dense plus exception merge join core.
// ----------------------------------------------------------------------------
package dpxmj_pkg;

	localparam int DENSE_DEPTH     = 4096;
	localparam int EXCEPTION_DEPTH = 1024;
	localparam int KEY_W           = 32;
	localparam int MAX_RUN         = 63;

	localparam int SLOT_W   = 12;
	localparam int OBJ_W    = 32;
	localparam int DENSE_AW = $clog2(DENSE_DEPTH);
	localparam int EXC_AW   = $clog2(EXCEPTION_DEPTH);
	localparam int DCNT_W   = $clog2(DENSE_DEPTH + 1);
	localparam int ECNT_W   = $clog2(EXCEPTION_DEPTH + 1);
	localparam int RUN_W    = $clog2(MAX_RUN + 1);

	localparam int IN_TDATA_W  = ((SLOT_W + KEY_W + OBJ_W + 7) / 8) * 8;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = KEY_W + OBJ_W;
	localparam int OUT_TUSER_W = 2;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;

	typedef enum logic [IN_TUSER_W-1:0] {
		OP_LOAD_DENSE = 2'd0,
		OP_LOAD_EXC   = 2'd1,
		OP_CAND       = 2'd2,
		OP_RESTART    = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DENSE_BASE = 2'd0,
		CFG_DENSE_CNT  = 2'd1,
		CFG_EXC_CNT    = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DENSE,
		ST_DCAP,
		ST_WALK,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic             lt;
		logic             eq;
		logic [KEY_W-1:0] diff;
	} cmp_res_t;

endpackage

// File: rtl/dpxmj_ram.sv
// ----------------------------------------------------------------------------
// dpxmj_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module dpxmj_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/dpxmj_cmp.sv
// ----------------------------------------------------------------------------
// dpxmj_cmp
// Shared key compare unit: subtract gives lt and diff; a direct == gives eq.
// ----------------------------------------------------------------------------
module dpxmj_cmp (
	input  logic [dpxmj_pkg::KEY_W-1:0] a,
	input  logic [dpxmj_pkg::KEY_W-1:0] b,
	output dpxmj_pkg::cmp_res_t         res
);

	logic [dpxmj_pkg::KEY_W:0] sub;

	assign sub      = {1'b0, a} - {1'b0, b};
	assign res.lt   = sub[dpxmj_pkg::KEY_W];
	assign res.eq   = (a == b);
	assign res.diff = sub[dpxmj_pkg::KEY_W-1:0];

endmodule

// File: rtl/dense_plus_exception_merge_join_core.sv
// ----------------------------------------------------------------------------
// dense_plus_exception_merge_join_core
// Joins ascending candidate keys against a dense object column and a sorted
// exception list, one compare per cycle through a shared compare unit.
// Loads and restart are taken in idle; a candidate steps through the dense
// read, dense capture, exception walk and flush states, plus output stalls.
// Throughput: one item at a time, set by the cursor walk over the exception
// RAM (one registered read and one compare per cycle unless a match waits).
// Reset: arst_n clears control, cursor, config registers; tables undefined.
// ----------------------------------------------------------------------------
module dense_plus_exception_merge_join_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// slot, subject_key, object_value, zero pad
	input  logic [dpxmj_pkg::IN_TDATA_W-1:0]      s_tdata,
	// opcode
	input  logic [dpxmj_pkg::IN_TUSER_W-1:0]      s_tuser,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// out_subject, out_object
	output logic [dpxmj_pkg::OUT_TDATA_W-1:0]     m_tdata,
	// from_exception, run_truncated
	output logic [dpxmj_pkg::OUT_TUSER_W-1:0]     m_tuser,
	output logic                                  m_tlast,
	input  logic                                  cfg_we,
	input  logic [dpxmj_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [dpxmj_pkg::CFG_DATA_W-1:0]      cfg_data
);

	dpxmj_pkg::state_t state_q, state_d;

	logic [dpxmj_pkg::KEY_W-1:0]  dense_base_q;
	logic [dpxmj_pkg::DCNT_W-1:0] dcount_q;
	logic [dpxmj_pkg::ECNT_W-1:0] ecount_q;
	logic [dpxmj_pkg::ECNT_W-1:0] cursor_q;
	logic [dpxmj_pkg::ECNT_W-1:0] cur_nxt;
	logic [dpxmj_pkg::RUN_W-1:0]  run_q;
	logic                         trunc_q;
	logic                         dhit_q;
	logic                         pend_valid_q;
	logic [dpxmj_pkg::OBJ_W-1:0]  pend_obj_q;
	logic                         pend_exc_q;
	logic [dpxmj_pkg::KEY_W-1:0]  key_q;

	logic                                m_tvalid_q;
	logic [dpxmj_pkg::OUT_TDATA_W-1:0]   m_tdata_q;
	logic [dpxmj_pkg::OUT_TUSER_W-1:0]   m_tuser_q;
	logic                                m_tlast_q;

	dpxmj_pkg::op_t               in_op;
	logic [dpxmj_pkg::SLOT_W-1:0] in_slot;
	logic [dpxmj_pkg::KEY_W-1:0]  in_key;
	logic [dpxmj_pkg::OBJ_W-1:0]  in_obj;
	logic                         in_acc;

	logic [dpxmj_pkg::KEY_W-1:0]  cmp_a, cmp_b;
	dpxmj_pkg::cmp_res_t          cmp;

	logic                                 d_we, d_re;
	logic [dpxmj_pkg::OBJ_W-1:0]          d_rdata;
	logic                                 e_we, e_re;
	logic [dpxmj_pkg::EXC_AW-1:0]         e_raddr;
	logic [dpxmj_pkg::KEY_W+dpxmj_pkg::OBJ_W-1:0] e_rdata;
	logic [dpxmj_pkg::KEY_W-1:0]          e_subj;
	logic [dpxmj_pkg::OBJ_W-1:0]          e_obj;

	logic out_free, cur_live, dhit_d;
	logic cur_inc, run_inc, set_trunc, pend_load, push, push_last;

	assign in_op   = dpxmj_pkg::op_t'(s_tuser);
	assign in_slot = s_tdata[dpxmj_pkg::SLOT_W-1:0];
	assign in_key  = s_tdata[dpxmj_pkg::SLOT_W +: dpxmj_pkg::KEY_W];
	assign in_obj  = s_tdata[dpxmj_pkg::SLOT_W + dpxmj_pkg::KEY_W +: dpxmj_pkg::OBJ_W];

	assign s_tready = (state_q == dpxmj_pkg::ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;

	assign out_free = !m_tvalid_q || m_tready;
	assign cur_live = (cursor_q < ecount_q);
	assign cur_nxt  = cursor_q + 1'b1;
	assign e_subj   = e_rdata[dpxmj_pkg::KEY_W-1:0];
	assign e_obj    = e_rdata[dpxmj_pkg::KEY_W +: dpxmj_pkg::OBJ_W];
	assign dhit_d   = !cmp.lt && (cmp.diff < dpxmj_pkg::KEY_W'(dcount_q));

	assign d_we = in_acc && (in_op == dpxmj_pkg::OP_LOAD_DENSE) &&
		({1'b0, in_slot} < (dpxmj_pkg::SLOT_W+1)'(dpxmj_pkg::DENSE_DEPTH));
	assign e_we = in_acc && (in_op == dpxmj_pkg::OP_LOAD_EXC) &&
		({1'b0, in_slot} < (dpxmj_pkg::SLOT_W+1)'(dpxmj_pkg::EXCEPTION_DEPTH));

	dpxmj_cmp u_cmp (
		.a   (cmp_a),
		.b   (cmp_b),
		.res (cmp)
	);

	dpxmj_ram #(
		.WIDTH (dpxmj_pkg::OBJ_W),
		.DEPTH (dpxmj_pkg::DENSE_DEPTH)
	) u_dense_ram (
		.clk   (clk),
		.we    (d_we),
		.waddr (in_slot[dpxmj_pkg::DENSE_AW-1:0]),
		.wdata (in_obj),
		.re    (d_re),
		.raddr (cmp.diff[dpxmj_pkg::DENSE_AW-1:0]),
		.rdata (d_rdata)
	);

	dpxmj_ram #(
		.WIDTH (dpxmj_pkg::KEY_W + dpxmj_pkg::OBJ_W),
		.DEPTH (dpxmj_pkg::EXCEPTION_DEPTH)
	) u_exc_ram (
		.clk   (clk),
		.we    (e_we),
		.waddr (in_slot[dpxmj_pkg::EXC_AW-1:0]),
		.wdata ({in_obj, in_key}),
		.re    (e_re),
		.raddr (e_raddr),
		.rdata (e_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dpxmj_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmp_a     = key_q;
		cmp_b     = dense_base_q;
		d_re      = 1'b0;
		e_re      = 1'b0;
		e_raddr   = cursor_q[dpxmj_pkg::EXC_AW-1:0];
		cur_inc   = 1'b0;
		run_inc   = 1'b0;
		set_trunc = 1'b0;
		pend_load = 1'b0;
		push      = 1'b0;
		push_last = 1'b0;
		unique case (state_q)
			dpxmj_pkg::ST_IDLE: begin
				if (in_acc && in_op == dpxmj_pkg::OP_CAND) begin
					state_d = dpxmj_pkg::ST_DENSE;
				end
			end
			dpxmj_pkg::ST_DENSE: begin
				d_re    = 1'b1;
				e_re    = 1'b1;
				state_d = dpxmj_pkg::ST_DCAP;
			end
			dpxmj_pkg::ST_DCAP: begin
				state_d = dpxmj_pkg::ST_WALK;
			end
			dpxmj_pkg::ST_WALK: begin
				cmp_a = e_subj;
				cmp_b = key_q;
				if (!cur_live) begin
					state_d = dpxmj_pkg::ST_FLUSH;
				end else if (cmp.lt) begin
					cur_inc = 1'b1;
					e_re    = 1'b1;
					e_raddr = cur_nxt[dpxmj_pkg::EXC_AW-1:0];
				end else if (cmp.eq) begin
					if (run_q < dpxmj_pkg::RUN_W'(dpxmj_pkg::MAX_RUN)) begin
						if (!pend_valid_q || out_free) begin
							push      = pend_valid_q;
							pend_load = 1'b1;
							run_inc   = 1'b1;
							cur_inc   = 1'b1;
							e_re      = 1'b1;
							e_raddr   = cur_nxt[dpxmj_pkg::EXC_AW-1:0];
						end
					end else begin
						set_trunc = 1'b1;
						cur_inc   = 1'b1;
						e_re      = 1'b1;
						e_raddr   = cur_nxt[dpxmj_pkg::EXC_AW-1:0];
					end
				end else begin
					state_d = dpxmj_pkg::ST_FLUSH;
				end
			end
			dpxmj_pkg::ST_FLUSH: begin
				if (!pend_valid_q) begin
					state_d = dpxmj_pkg::ST_IDLE;
				end else if (out_free) begin
					push      = 1'b1;
					push_last = 1'b1;
					state_d   = dpxmj_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dpxmj_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dense_base_q <= '0;
			dcount_q     <= '0;
			ecount_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				dpxmj_pkg::CFG_DENSE_BASE: begin
					dense_base_q <= cfg_data[dpxmj_pkg::KEY_W-1:0];
				end
				dpxmj_pkg::CFG_DENSE_CNT: begin
					dcount_q <= (cfg_data[dpxmj_pkg::DCNT_W-1:0] >
						dpxmj_pkg::DCNT_W'(dpxmj_pkg::DENSE_DEPTH)) ?
						dpxmj_pkg::DCNT_W'(dpxmj_pkg::DENSE_DEPTH) :
						cfg_data[dpxmj_pkg::DCNT_W-1:0];
				end
				dpxmj_pkg::CFG_EXC_CNT: begin
					ecount_q <= (cfg_data[dpxmj_pkg::ECNT_W-1:0] >
						dpxmj_pkg::ECNT_W'(dpxmj_pkg::EXCEPTION_DEPTH)) ?
						dpxmj_pkg::ECNT_W'(dpxmj_pkg::EXCEPTION_DEPTH) :
						cfg_data[dpxmj_pkg::ECNT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q     <= '0;
			run_q        <= '0;
			trunc_q      <= 1'b0;
			dhit_q       <= 1'b0;
			pend_valid_q <= 1'b0;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (in_acc && in_op == dpxmj_pkg::OP_RESTART) begin
				cursor_q <= '0;
			end else if (cur_inc) begin
				cursor_q <= cur_nxt;
			end

			if (in_acc && in_op == dpxmj_pkg::OP_CAND) begin
				run_q   <= '0;
				trunc_q <= 1'b0;
			end else begin
				if (run_inc) begin
					run_q <= run_q + 1'b1;
				end
				if (set_trunc) begin
					trunc_q <= 1'b1;
				end
			end

			if (state_q == dpxmj_pkg::ST_DENSE) begin
				dhit_q <= dhit_d;
			end

			if ((state_q == dpxmj_pkg::ST_DCAP && dhit_q) || pend_load) begin
				pend_valid_q <= 1'b1;
			end else if (push_last) begin
				pend_valid_q <= 1'b0;
			end

			if (push) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && in_op == dpxmj_pkg::OP_CAND) begin
			key_q <= in_key;
		end
		if (state_q == dpxmj_pkg::ST_DCAP && dhit_q) begin
			pend_obj_q <= d_rdata;
			pend_exc_q <= 1'b0;
		end else if (pend_load) begin
			pend_obj_q <= e_obj;
			pend_exc_q <= 1'b1;
		end
		if (push) begin
			m_tdata_q <= {pend_obj_q, key_q};
			m_tuser_q <= {push_last && trunc_q, pend_exc_q};
			m_tlast_q <= push_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule

// File: rtl/dpxmj_chk.sv
// ----------------------------------------------------------------------------
// dpxmj_chk
// Port-level checks of the merge join core, bound to the top level.
// ----------------------------------------------------------------------------
module dpxmj_chk (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  s_tvalid,
	input logic                                  s_tready,
	input logic [dpxmj_pkg::IN_TDATA_W-1:0]      s_tdata,
	input logic [dpxmj_pkg::IN_TUSER_W-1:0]      s_tuser,
	input logic                                  m_tvalid,
	input logic                                  m_tready,
	input logic [dpxmj_pkg::OUT_TDATA_W-1:0]     m_tdata,
	input logic [dpxmj_pkg::OUT_TUSER_W-1:0]     m_tuser,
	input logic                                  m_tlast,
	input logic                                  cfg_we,
	input logic [dpxmj_pkg::CFG_IDX_W-1:0]       cfg_index,
	input logic [dpxmj_pkg::CFG_DATA_W-1:0]      cfg_data
);

	// stalled result item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
		$stable(m_tuser) && $stable(m_tlast))
		else $error("result item changed while stalled");

	// truncation flag only on the last item of a run
	a_trunc_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tlast)
		else $error("run_truncated set on a non-final item");

	// the input is not ready in the cycle after a candidate item is taken
	a_cand_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == dpxmj_pkg::OP_CAND |=> !s_tready)
		else $error("ready right after a candidate item");

	// a run in flight keeps the input closed
	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("input ready with a run still open");

endmodule

bind dense_plus_exception_merge_join_core dpxmj_chk u_dpxmj_chk (.*);

// File: sim/dense_plus_exception_merge_join_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dense_plus_exception_merge_join_core_tb
// Self-checking bench for the dense plus exception merge join core. Tables are
// loaded through the input stream and candidate keys are then joined against
// them. A behavioral join model built into the bench predicts every result
// pair. Results are compared field by field, in order. Both stream sides
// idle at random, and one phase holds the output off long enough to back up
// the input.
// ----------------------------------------------------------------------------
module dense_plus_exception_merge_join_core_tb;
	import dpxmj_pkg::*;

	localparam int PAD_W       = IN_TDATA_W - SLOT_W - KEY_W - OBJ_W;
	localparam int HOLD_CYCLES = 300;
	// worst case is far below this: ~500 items, each with long gaps, walks and stalls
	localparam int CYCLE_LIMIT = 500000;
	localparam int MAX_PRINTS  = 40;

	typedef struct packed {
		logic [KEY_W-1:0] subject;
		logic [OBJ_W-1:0] object;
		logic             from_exc;
		logic             last;
		logic             trunc;
	} join_pair_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic [IN_TUSER_W-1:0]  s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [OUT_TUSER_W-1:0] m_tuser;
	logic                   m_tlast;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	dense_plus_exception_merge_join_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	logic [OBJ_W-1:0]  dense_column [DENSE_DEPTH];
	logic [KEY_W-1:0]  exc_subject [EXCEPTION_DEPTH];
	logic [OBJ_W-1:0]  exc_object [EXCEPTION_DEPTH];
	int                scan_pos;
	logic [KEY_W-1:0]  reg_dense_base;
	logic [DCNT_W-1:0] reg_dense_count;
	logic [ECNT_W-1:0] reg_exc_count;
	join_pair_t        pending_pairs [$];

	bit tx_idle_on;
	bit rx_idle_on;
	bit hold_request;
	int error_count;
	int items_accepted;
	int candidates_sent;
	int results_checked;
	int capped_runs;
	int cycle_count;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("watchdog expired after %0d cycles, %0d results pending",
			cycle_count, pending_pairs.size());
		$display("simulation failed");
		$finish;
	end

	function automatic int idle_gap();
		int r;
		r = $urandom_range(99, 0);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	function automatic int exc_limit();
		return (reg_exc_count > EXCEPTION_DEPTH) ? EXCEPTION_DEPTH : int'(reg_exc_count);
	endfunction

	// join model: updates tables and cursor, queues the pairs a candidate yields
	function automatic void join_predict(input op_t op, input logic [SLOT_W-1:0] slot,
			input logic [KEY_W-1:0] key, input logic [OBJ_W-1:0] obj);
		int         dlim;
		int         elim;
		int         produced;
		int         run_len;
		bit         dropped;
		join_pair_t rec;
		case (op)
			OP_LOAD_DENSE: begin
				dense_column[slot] = obj;
			end
			OP_LOAD_EXC: begin
				if (slot < EXCEPTION_DEPTH) begin
					exc_subject[slot[EXC_AW-1:0]] = key;
					exc_object[slot[EXC_AW-1:0]]  = obj;
				end
			end
			OP_RESTART: begin
				scan_pos = 0;
			end
			default: begin
				dlim = (reg_dense_count > DENSE_DEPTH) ? DENSE_DEPTH : int'(reg_dense_count);
				elim = exc_limit();
				produced = 0;
				run_len = 0;
				dropped = 1'b0;
				if (key >= reg_dense_base && (key - reg_dense_base) < dlim) begin
					rec = '{key, dense_column[DENSE_AW'(key - reg_dense_base)], 1'b0, 1'b0, 1'b0};
					pending_pairs.push_back(rec);
					produced++;
				end
				while (scan_pos < elim && exc_subject[scan_pos] < key)
					scan_pos++;
				while (scan_pos < elim && exc_subject[scan_pos] == key) begin
					if (run_len < MAX_RUN) begin
						rec = '{key, exc_object[scan_pos], 1'b1, 1'b0, 1'b0};
						pending_pairs.push_back(rec);
						produced++;
						run_len++;
					end else begin
						dropped = 1'b1;
					end
					scan_pos++;
				end
				if (produced > 0) begin
					rec = pending_pairs.pop_back();
					rec.last  = 1'b1;
					rec.trunc = dropped;
					pending_pairs.push_back(rec);
				end
			end
		endcase
	endfunction

	task automatic offer_item(input op_t op, input logic [SLOT_W-1:0] slot,
			input logic [KEY_W-1:0] key, input logic [OBJ_W-1:0] obj);
		int gap;
		gap = tx_idle_on ? idle_gap() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {{PAD_W{1'b0}}, obj, key, slot};
		do @(posedge clk); while (s_tready !== 1'b1);
		items_accepted++;
		if (op == OP_CAND)
			candidates_sent++;
		join_predict(op, slot, key, obj);
	endtask

	task automatic load_dense(input logic [SLOT_W-1:0] slot, input logic [OBJ_W-1:0] obj);
		offer_item(OP_LOAD_DENSE, slot, $urandom(), obj);
	endtask

	task automatic load_exc(input logic [SLOT_W-1:0] slot, input logic [KEY_W-1:0] key,
			input logic [OBJ_W-1:0] obj);
		offer_item(OP_LOAD_EXC, slot, key, obj);
	endtask

	task automatic candidate(input logic [KEY_W-1:0] key);
		offer_item(OP_CAND, $urandom(), key, $urandom());
	endtask

	task automatic restart_scan();
		offer_item(OP_RESTART, $urandom(), $urandom(), $urandom());
	endtask

	// all results in, then let a long cursor walk with no output finish
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_pairs.size() != 0)
			@(posedge clk);
		repeat (20 + exc_limit()) @(posedge clk);
	endtask

	task automatic set_regs(input logic [KEY_W-1:0] base, input logic [CFG_DATA_W-1:0] dcnt,
			input logic [CFG_DATA_W-1:0] ecnt);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_index <= CFG_DENSE_BASE;
		cfg_data  <= base;
		@(posedge clk);
		cfg_index <= CFG_DENSE_CNT;
		cfg_data  <= dcnt;
		@(posedge clk);
		cfg_index <= CFG_EXC_CNT;
		cfg_data  <= ecnt;
		@(posedge clk);
		cfg_we <= 1'b0;
		reg_dense_base  = base;
		reg_dense_count = dcnt[DCNT_W-1:0];
		reg_exc_count   = ecnt[ECNT_W-1:0];
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] exp_val);
		error_count++;
		if (error_count <= MAX_PRINTS)
			$display("[%0t] mismatch on %s: got %h, want %h", $time, what, got, exp_val);
	endtask

	initial begin : output_sink
		int stall_left;
		stall_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if (rx_idle_on && $urandom_range(99, 0) < 30) begin
				m_tready <= 1'b0;
				stall_left = idle_gap();
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin : result_check
		join_pair_t seen;
		join_pair_t want;
		forever begin
			@(posedge clk);
			if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
				seen = {m_tdata[KEY_W-1:0], m_tdata[KEY_W +: OBJ_W], m_tuser[0], m_tlast,
					m_tuser[1]};
				results_checked++;
				if (pending_pairs.size() == 0) begin
					report_mismatch("unexpected item, subject", seen.subject, '0);
				end else begin
					want = pending_pairs.pop_front();
					if (seen.subject !== want.subject)
						report_mismatch("out_subject", seen.subject, want.subject);
					if (seen.object !== want.object)
						report_mismatch("out_object", seen.object, want.object);
					if (seen.from_exc !== want.from_exc)
						report_mismatch("from_exception", seen.from_exc, want.from_exc);
					if (seen.last !== want.last)
						report_mismatch("last_of_run", seen.last, want.last);
					if (seen.trunc !== want.trunc)
						report_mismatch("run_truncated", seen.trunc, want.trunc);
					if (want.trunc)
						capped_runs++;
				end
			end
		end
	end

	// tables loaded in full over the whole range, so any key is a legal probe
	task automatic run_join_phase(input logic [KEY_W-1:0] base, input int dcnt,
			input int nexc, input int ncand, input bit hold_output);
		logic [KEY_W-1:0] start_key;
		logic [KEY_W-1:0] subj;
		logic [KEY_W-1:0] next_key;
		logic [KEY_W-1:0] probe;
		int               sent;
		int               r;
		start_key = (base >= 4) ? base - 4 : '0;
		set_regs(base, dcnt, nexc);
		for (int i = 0; i < dcnt; i++)
			load_dense(i, $urandom());
		subj = start_key;
		for (int i = 0; i < nexc; i++) begin
			subj = subj + $urandom_range(2, 0);
			load_exc(i, subj, $urandom());
			if ($urandom_range(99, 0) < 10)
				load_exc($urandom_range(4095, EXCEPTION_DEPTH), $urandom(), $urandom());
			if ($urandom_range(99, 0) < 5)
				load_dense($urandom_range(4095, 0), $urandom());
		end
		restart_scan();
		if (hold_output)
			hold_request = 1'b1;
		next_key = start_key;
		sent = 0;
		while (sent < ncand) begin
			r = $urandom_range(99, 0);
			if (r < 5) begin
				restart_scan();
			end else if (r < 8) begin
				candidate($urandom());
				restart_scan();
				sent++;
			end else if (r < 14) begin
				probe = next_key - $urandom_range(5, 1);
				if (probe > next_key)
					probe = '0;
				candidate(probe);
				sent++;
			end else begin
				next_key = next_key + $urandom_range(2, 0);
				candidate(next_key);
				sent++;
			end
		end
	endtask

	task automatic test_reset_state();
		candidate('0);
		candidate('1);
		set_regs('1, 1, 0);
		load_dense(0, $urandom());
		candidate(32'hFFFF_FFFE);
		candidate('1);
	endtask

	task automatic test_directed_join();
		set_regs(100, 5, 4);
		for (int i = 0; i < 5; i++)
			load_dense(i, $urandom());
		load_dense(4095, $urandom());
		load_exc(0, 98, $urandom());
		load_exc(1, 101, $urandom());
		load_exc(2, 101, $urandom());
		load_exc(3, 103, $urandom());
		// out of range slot, aliases onto a live entry if not dropped
		load_exc(EXCEPTION_DEPTH + 2, 0, $urandom());
		restart_scan();
		candidate(99);
		candidate(100);
		candidate(101);
		candidate(102);
		candidate(103);
		candidate(104);
		candidate(101);
		candidate('1);
		restart_scan();
		candidate(101);
	endtask

	task automatic test_count_saturation();
		set_regs(0, 13'h1FFF, 11'h7FF);
		load_dense(0, $urandom());
		load_dense(4095, $urandom());
		load_exc(0, 4095, $urandom());
		load_exc(1, 4096, $urandom());
		load_exc(2, '1, $urandom());
		restart_scan();
		candidate(0);
		candidate(4095);
		candidate(4096);
		candidate(5000);
		candidate(32'h7FFF_FFFF);
	endtask

	task automatic test_run_cap();
		set_regs(500, 1, 128);
		load_dense(0, $urandom());
		for (int i = 0; i < 64; i++)
			load_exc(i, 500, $urandom());
		load_exc(64, 501, $urandom());
		for (int i = 65; i < 128; i++)
			load_exc(i, 502, $urandom());
		restart_scan();
		candidate(500);
		candidate(501);
		candidate(502);
	endtask

	task automatic test_random_join();
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		run_join_phase(0, 12, 20, 35, 1'b0);
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		run_join_phase($urandom_range(32'hFFFF_FF00, 16), $urandom_range(24, 1),
			$urandom_range(30, 8), 35, 1'b0);
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		run_join_phase(32'hFFFF_FF80, 40, 30, 40, 1'b0);
	endtask

	task automatic test_backpressure();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b1;
		run_join_phase($urandom_range(32'hFFFF_FF00, 16), 16, 24, 20, 1'b1);
		tx_idle_on = 1'b1;
	endtask

	initial begin
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= OP_LOAD_DENSE;
		cfg_we    <= 1'b0;
		cfg_index <= CFG_DENSE_BASE;
		cfg_data  <= '0;
		reg_dense_base  = '0;
		reg_dense_count = '0;
		reg_exc_count   = '0;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_directed_join();
		test_count_saturation();
		test_run_cap();
		test_random_join();
		test_backpressure();
		wait_idle();

		$display("covered %0d items (%0d candidate keys), %0d result pairs checked",
			items_accepted, candidates_sent, results_checked);
		$display("capped runs seen: %0d, mismatches: %0d", capped_runs, error_count);
		if (error_count == 0 && pending_pairs.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// File: files.f
rtl/dpxmj_pkg.sv
rtl/dpxmj_ram.sv
rtl/dpxmj_cmp.sv
rtl/dense_plus_exception_merge_join_core.sv
rtl/dpxmj_chk.sv
sim/dense_plus_exception_merge_join_core_tb.sv
